// File: hw/rtl/lztb_pkg.sv
// Shared types, codes and helpers for the LZ token bitstream encoder.
// No dependencies; imported by every module of the block.
package lztb_pkg;

    localparam int OUT_DEPTH_DEF = 65536;
    localparam int LEN_WIDTH_DEF = 16;

    // gamma operands: lengths up to 24 bits plus headroom
    localparam int GAM_W = 25;
    localparam int TOP_W = 5;

    localparam logic [1:0] REQ_LIT_HDR  = 2'd0;
    localparam logic [1:0] REQ_LIT_BYTE = 2'd1;
    localparam logic [1:0] REQ_MATCH    = 2'd2;
    localparam logic [1:0] REQ_END      = 2'd3;

    localparam logic [1:0] CFG_BACKWARDS   = 2'd0;
    localparam logic [1:0] CFG_INVERT      = 2'd1;
    localparam logic [1:0] CFG_INIT_OFFSET = 2'd2;

    localparam logic [GAM_W-1:0] END_CODE = GAM_W'(256);

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] run_length;
        logic [15:0] match_offset;
        logic [7:0]  literal_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] write_addr;
        logic [7:0]  write_data;
        logic        last_write;
    } out_item_t;

    typedef struct packed {
        logic        rev_mode;
        logic        inv_mode;
        logic [15:0] start_offset;
    } cfg_t;

    // one classified token, as the back end carries it out
    typedef struct packed {
        logic [2:0]       pre_bits;   // left aligned prefix bits
        logic [1:0]       pre_cnt;
        logic             g1_en;
        logic             g1_inv;
        logic [GAM_W-1:0] g1_val;
        logic [TOP_W-1:0] g1_top;
        logic             byte_en;
        logic [7:0]       byte_data;
        logic             g2_en;
        logic [GAM_W-1:0] g2_val;
        logic [TOP_W-1:0] g2_top;
        logic             end_en;
    } cmd_t;

    // index of leading one; zero is coded like one
    function automatic logic [TOP_W-1:0] msb_pos(input logic [GAM_W-1:0] v);
        logic [TOP_W-1:0] p;
        p = '0;
        for (int i = 0; i < GAM_W; i++)
        begin
            if (v[i])
            begin
                p = TOP_W'(i);
            end
        end
        return p;
    endfunction

endpackage

// File: hw/rtl/lztb_front.sv
// Front end: accepts tokens, tracks recent offsets, builds bit-code commands.
// Depends on lztb_pkg.
module lztb_front
    import lztb_pkg::*;
#(
    parameter int LEN_WIDTH = LEN_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        load_a,
    input  logic [15:0] load_val,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    localparam logic [31:0] LEN_MAX = (32'd1 << LEN_WIDTH) - 32'd1;

    logic [15:0] ra_reg, rb_reg, rc_reg;
    logic [15:0] ra_next, rb_next, rc_next;
    logic [31:0] run32;
    logic [GAM_W-1:0] len_sat, len_m1;
    logic [15:0] off, offm1;
    logic [GAM_W-1:0] hi;
    logic [7:0] lo;
    logic accept;

    assign accept    = in_valid && cmd_ready;
    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;

    assign run32   = 32'(in_item.run_length);
    assign len_sat = (run32 > LEN_MAX) ? GAM_W'(LEN_MAX) : GAM_W'(run32);
    assign len_m1  = (len_sat == '0) ? '0 : len_sat - GAM_W'(1);
    assign off     = (in_item.match_offset == 16'd0) ? 16'd1 : in_item.match_offset;
    assign offm1   = off - 16'd1;
    assign hi      = GAM_W'(offm1[15:8]) + GAM_W'(1);
    assign lo      = offm1[7:0];

    always_comb
    begin
        cmd = '0;
        ra_next = ra_reg;
        rb_next = rb_reg;
        rc_next = rc_reg;
        cmd.g1_val = len_sat;
        cmd.g1_top = msb_pos(len_sat);
        unique case (in_item.req_type)
            REQ_LIT_HDR:
            begin
                cmd.pre_cnt = 2'd1;
                cmd.g1_en   = 1'b1;
            end
            REQ_LIT_BYTE:
            begin
                cmd.byte_en   = 1'b1;
                cmd.byte_data = in_item.literal_byte;
            end
            REQ_MATCH:
            begin
                cmd.g1_en = 1'b1;
                if (off == ra_reg)
                begin
                    cmd.pre_cnt = 2'd1;
                end
                else if (off == rb_reg)
                begin
                    cmd.pre_bits = 3'b100;
                    cmd.pre_cnt  = 2'd3;
                    rb_next = ra_reg;
                    ra_next = off;
                end
                else if (off == rc_reg)
                begin
                    cmd.pre_bits = 3'b101;
                    cmd.pre_cnt  = 2'd3;
                    rc_next = rb_reg;
                    rb_next = ra_reg;
                    ra_next = off;
                end
                else
                begin
                    cmd.pre_bits  = {2'b11, (len_sat > GAM_W'(2)) ? cfg.rev_mode
                                                                  : ~cfg.rev_mode};
                    cmd.pre_cnt   = 2'd3;
                    cmd.g1_inv    = cfg.inv_mode;
                    cmd.g1_val    = hi;
                    cmd.g1_top    = msb_pos(hi);
                    cmd.byte_en   = 1'b1;
                    cmd.byte_data = cfg.rev_mode ? lo : ~lo;
                    cmd.g2_en     = 1'b1;
                    cmd.g2_val    = len_m1;
                    cmd.g2_top    = msb_pos(len_m1);
                    rc_next = rb_reg;
                    rb_next = ra_reg;
                    ra_next = off;
                end
            end
            REQ_END:
            begin
                cmd.pre_bits = 3'b110;
                cmd.pre_cnt  = 2'd3;
                cmd.g1_en    = 1'b1;
                cmd.g1_inv   = cfg.inv_mode;
                cmd.g1_val   = END_CODE;
                cmd.g1_top   = msb_pos(END_CODE);
                cmd.end_en   = 1'b1;
                ra_next = cfg.start_offset;
                rb_next = 16'd0;
                rc_next = 16'd0;
            end
            default:
            begin
                cmd.g1_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ra_reg <= 16'd1;
            rb_reg <= 16'd0;
            rc_reg <= 16'd0;
        end
        else if (load_a)
        begin
            ra_reg <= load_val;
        end
        else if (accept)
        begin
            ra_reg <= ra_next;
            rb_reg <= rb_next;
            rc_reg <= rc_next;
        end
    end

endmodule

// File: hw/rtl/lztb_queue.sv
// Two-entry command queue between front and back end.
// Depends on lztb_pkg.
module lztb_queue
    import lztb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output cmd_t rd_data
);

    cmd_t       mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: hw/rtl/lztb_back.sv
// Back end: shifts control bits into flag bytes, places data bytes, emits writes.
// Depends on lztb_pkg.
module lztb_back
    import lztb_pkg::*;
#(
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rev_mode,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int AW = $clog2(OUT_DEPTH);

    typedef enum logic [2:0] {P_IDLE, P_PRE, P_G1, P_BYTE, P_G2, P_FLUSH, P_FIN} phase_t;

    phase_t           phase_reg, phase_next;
    cmd_t             cmd_reg, cmd_next;
    logic [2:0]       pre_reg, pre_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [TOP_W-1:0] pos_reg, pos_next;
    logic             half_reg, half_next;
    logic             supp_reg, supp_next;
    logic [3:0]       left_reg, left_next;
    logic [7:0]       bits_reg, bits_next;
    logic [AW-1:0]    faddr_reg, faddr_next;
    logic [AW-1:0]    naddr_reg, naddr_next;
    logic             pend_valid_reg;
    out_item_t        pend_reg;
    logic             out_valid_reg;
    out_item_t        out_reg;

    logic          bit_req, bit_val, emit, finish, hold, out_free;
    logic [AW-1:0] e_addr;
    logic [7:0]    e_data;

    function automatic phase_t after(input phase_t p, input cmd_t c);
        phase_t n;
        n = P_FIN;
        if (c.end_en)
        begin
            n = P_FLUSH;
        end
        if (c.g2_en && (p == P_PRE || p == P_G1 || p == P_BYTE))
        begin
            n = P_G2;
        end
        if (c.byte_en && (p == P_PRE || p == P_G1))
        begin
            n = P_BYTE;
        end
        if (c.g1_en && p == P_PRE)
        begin
            n = P_G1;
        end
        return n;
    endfunction

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        return (a == AW'(OUT_DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [15:0] addr_fmt(input logic [AW-1:0] a);
        logic [AW+15:0] w;
        w = {16'd0, a};
        return w[15:0];
    endfunction

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign cmd_ready = (phase_reg == P_IDLE);
    assign hold      = (emit || finish) && pend_valid_reg && !out_free;

    always_comb
    begin
        logic             gbit_inv;
        logic [GAM_W-1:0] gv;
        logic [3:0]       l;
        logic [7:0]       b;
        logic [AW-1:0]    fa;

        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        pre_next   = pre_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        half_next  = half_reg;
        supp_next  = supp_reg;
        left_next  = left_reg;
        bits_next  = bits_reg;
        faddr_next = faddr_reg;
        naddr_next = naddr_reg;
        bit_req = 1'b0;
        bit_val = 1'b0;
        emit    = 1'b0;
        finish  = 1'b0;
        e_addr  = naddr_reg;
        e_data  = cmd_reg.byte_data;
        l  = left_reg;
        b  = bits_reg;
        fa = faddr_reg;
        gbit_inv = (phase_reg == P_G1) ? cmd_reg.g1_inv : 1'b0;
        gv       = (phase_reg == P_G1) ? cmd_reg.g1_val : cmd_reg.g2_val;

        unique case (phase_reg)
            P_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    pre_next   = cmd.pre_bits;
                    cnt_next   = cmd.pre_cnt;
                    phase_next = (cmd.pre_cnt != 2'd0) ? P_PRE : after(P_PRE, cmd);
                end
            end
            P_PRE:
            begin
                bit_req  = 1'b1;
                bit_val  = pre_reg[2];
                pre_next = {pre_reg[1:0], 1'b0};
                cnt_next = cnt_reg - 2'd1;
                if (cnt_reg == 2'd1)
                begin
                    phase_next = after(P_PRE, cmd_reg);
                end
            end
            P_G1, P_G2:
            begin
                bit_req = 1'b1;
                if (pos_reg == '0)
                begin
                    bit_val    = ~rev_mode;   // stop bit
                    phase_next = after(phase_reg, cmd_reg);
                end
                else if (!half_reg)
                begin
                    bit_val   = rev_mode;     // continuation bit
                    half_next = 1'b1;
                end
                else
                begin
                    bit_val   = gv[pos_reg - TOP_W'(1)] ^ gbit_inv;
                    half_next = 1'b0;
                    pos_next  = pos_reg - TOP_W'(1);
                end
            end
            P_BYTE:
            begin
                emit       = 1'b1;
                naddr_next = addr_inc(naddr_reg);
                if (cmd_reg.g2_en)
                begin
                    supp_next = 1'b1;
                end
                phase_next = after(P_BYTE, cmd_reg);
            end
            P_FLUSH:
            begin
                if (left_reg != 4'd0)
                begin
                    emit   = 1'b1;
                    e_addr = faddr_reg;
                    e_data = bits_reg;
                end
                left_next  = 4'd0;
                bits_next  = 8'd0;
                supp_next  = 1'b1;
                phase_next = P_FIN;
            end
            P_FIN:
            begin
                finish     = 1'b1;
                phase_next = P_IDLE;
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase

        if (bit_req)
        begin
            if (supp_reg)
            begin
                supp_next = 1'b0;
            end
            else
            begin
                if (l == 4'd0)
                begin
                    fa = naddr_reg;
                    naddr_next = addr_inc(naddr_reg);
                    b = 8'd0;
                    l = 4'd8;
                end
                b[3'(l - 4'd1)] = bit_val;
                l = l - 4'd1;
                if (l == 4'd0)
                begin
                    emit   = 1'b1;
                    e_addr = fa;
                    e_data = b;
                end
                left_next  = l;
                bits_next  = b;
                faddr_next = fa;
            end
        end

        // gamma position counter loads on entry
        if (phase_next == P_G1 && phase_reg != P_G1)
        begin
            pos_next  = cmd_next.g1_top;
            half_next = 1'b0;
        end
        else if (phase_next == P_G2 && phase_reg != P_G2)
        begin
            pos_next  = cmd_next.g2_top;
            half_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            cmd_reg <= cmd_next;
            pre_reg <= pre_next;
            pos_reg <= pos_next;
            if (emit)
            begin
                pend_reg.write_addr <= addr_fmt(e_addr);
                pend_reg.write_data <= e_data;
                pend_reg.last_write <= 1'b0;
            end
        end
        if (out_free)
        begin
            out_reg <= {pend_reg.write_addr, pend_reg.write_data, finish};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= P_IDLE;
            cnt_reg        <= 2'd0;
            half_reg       <= 1'b0;
            supp_reg       <= 1'b1;
            left_reg       <= 4'd0;
            bits_reg       <= 8'd0;
            faddr_reg      <= '0;
            naddr_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!hold)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                half_reg  <= half_next;
                supp_reg  <= supp_next;
                left_reg  <= left_next;
                bits_reg  <= bits_next;
                faddr_reg <= faddr_next;
                naddr_reg <= naddr_next;
                if (emit)
                begin
                    pend_valid_reg <= 1'b1;
                end
                else if (finish)
                begin
                    pend_valid_reg <= 1'b0;
                end
            end
            if (out_free)
            begin
                out_valid_reg <= (emit || finish) && pend_valid_reg;
            end
        end
    end

endmodule

// File: hw/rtl/lz_token_bitstream_encoder_unit.sv
// Top level of the LZ token bitstream encoder: config registers, front end,
// command queue and back end. Depends on lztb_pkg, lztb_front, lztb_queue, lztb_back.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  input   | in_valid, in_ready, in_item      | tokens in
//  output  | out_valid, out_ready, out_item   | addressed byte writes out
//  config  | cfg_valid, cfg_ready, cfg_index, | register writes in
//          | cfg_data                         |
//
// The front end classifies a token in the cycle it is accepted and queues a
// command (two entries). The back end loads a command, then shifts one control
// bit or places one data byte per cycle while the output does not stall, then
// runs an end flush for an end token and a closing step; its flag-byte shifter
// takes a single bit at a time. The last write of a token is held back one
// write so it can carry last_write; the closing step hands it to the output
// register. Reset is asynchronous, active low, and leaves a fresh stream at
// address zero. Output stalls hold the back end only; the queue keeps the front
// end accepting until its two entries fill. Config writes always land.
module lz_token_bitstream_encoder_unit
    import lztb_pkg::*;
#(
    parameter int OUT_DEPTH = OUT_DEPTH_DEF,
    parameter int LEN_WIDTH = LEN_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t cfg_reg;
    logic load_a;
    logic q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    cmd_t q_in, q_out;

    assign cfg_ready = 1'b1;
    assign load_a    = cfg_valid && (cfg_index == CFG_INIT_OFFSET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rev_mode     <= 1'b0;
            cfg_reg.inv_mode     <= 1'b0;
            cfg_reg.start_offset <= 16'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BACKWARDS:   cfg_reg.rev_mode     <= cfg_data[0];
                CFG_INVERT:      cfg_reg.inv_mode     <= cfg_data[0];
                CFG_INIT_OFFSET: cfg_reg.start_offset <= cfg_data;
                default:         cfg_reg <= cfg_reg;   // unused index
            endcase
        end
    end

    lztb_front #(.LEN_WIDTH(LEN_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .load_a    (load_a),
        .load_val  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cmd_valid (q_in_valid),
        .cmd_ready (q_in_ready),
        .cmd       (q_in)
    );

    lztb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_in_valid),
        .wr_ready (q_in_ready),
        .wr_data  (q_in),
        .rd_valid (q_out_valid),
        .rd_ready (q_out_ready),
        .rd_data  (q_out)
    );

    lztb_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rev_mode  (cfg_reg.rev_mode),
        .cmd_valid (q_out_valid),
        .cmd_ready (q_out_ready),
        .cmd       (q_out),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
